/* rtl/assert_macros.svh */
// Assertion macros used by the histogram top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Assert that an implication holds at every clock edge out of reset.
`define ASSERT_IMPL(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Assert that a condition never holds out of reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`endif

/* rtl/wh2d_pkg.sv */
// Package of the weighted 2D histogram: sizes, codes and arithmetic helpers.
`default_nettype none
package wh2d_pkg;
    localparam int MAX_BINS_X = 32;
    localparam int MAX_BINS_Y = 32;
    localparam int NCELLS     = MAX_BINS_X * MAX_BINS_Y;
    localparam int CELL_AW    = $clog2(NCELLS);
    localparam int BX_W       = $clog2(MAX_BINS_X + 1);
    localparam int BY_W       = $clog2(MAX_BINS_Y + 1);
    localparam int IX_W       = (MAX_BINS_X > 1) ? $clog2(MAX_BINS_X) : 1;
    localparam int IY_W       = (MAX_BINS_Y > 1) ? $clog2(MAX_BINS_Y) : 1;
    localparam int CLR_W      = CELL_AW + 1;

    // Function codes of an input item.
    localparam logic [1:0] FUNC_FILL  = 2'd0;
    localparam logic [1:0] FUNC_READ  = 2'd1;
    localparam logic [1:0] FUNC_INTEG = 2'd2;

    // Configuration register indexes.
    localparam logic [2:0] REG_MIN_X   = 3'd0;
    localparam logic [2:0] REG_MAX_X   = 3'd1;
    localparam logic [2:0] REG_MIN_Y   = 3'd2;
    localparam logic [2:0] REG_MAX_Y   = 3'd3;
    localparam logic [2:0] REG_BINS_X  = 3'd4;
    localparam logic [2:0] REG_BINS_Y  = 3'd5;
    localparam logic [2:0] REG_SCALE_X = 3'd6;
    localparam logic [2:0] REG_SCALE_Y = 3'd7;

    // Region codes.
    localparam logic [3:0] RGN_IN     = 4'd0;
    localparam logic [3:0] RGN_XLO    = 4'd1;
    localparam logic [3:0] RGN_XHI    = 4'd2;
    localparam logic [3:0] RGN_YLO    = 4'd3;
    localparam logic [3:0] RGN_YHI    = 4'd4;
    localparam logic [3:0] RGN_XLOYLO = 4'd5;
    localparam logic [3:0] RGN_XLOYHI = 4'd6;
    localparam logic [3:0] RGN_XHIYLO = 4'd7;
    localparam logic [3:0] RGN_XHIYHI = 4'd8;

    localparam logic [10:0] EDGE_BASE = 11'd1024;
    localparam logic [10:0] EDGE_END  = 11'd1032;

    typedef enum logic [2:0] {
        ST_CLEAR, ST_IDLE, ST_BIN, ST_LOOKUP, ST_UPDATE, ST_SUM, ST_SUM_LAST, ST_OUT
    } state_t;

    // Saturating 48-bit signed add.
    function automatic logic signed [47:0] sat_add48(input logic signed [47:0] a,
                                                     input logic signed [47:0] b);
        logic signed [48:0] s;
        s = {a[47], a} + {b[47], b};
        if (s[48] != s[47])
            return s[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
        return s[47:0];
    endfunction

    // Saturating 32-bit increment.
    function automatic logic [31:0] sat_inc32(input logic [31:0] a);
        return (a == '1) ? a : a + 32'd1;
    endfunction
endpackage
`default_nettype wire

/* rtl/wh2d_binner.sv */
// Two-stage bin index unit: offset times scale, then shift and clamp.
`default_nettype none
module wh2d_binner
    import wh2d_pkg::*;
(
    input  wire logic               clk,
    input  wire logic signed [15:0] coord,
    input  wire logic signed [15:0] lo,
    input  wire logic [31:0]        scale,
    input  wire logic [BX_W-1:0]    nbins,
    output logic [IX_W-1:0]         index
);
    logic [16:0] diff;
    logic [47:0] prod_reg;
    logic [31:0] idx_raw;

    // Offset is taken modulo 2^16, as the value is known to be nonnegative.
    assign diff = {coord[15], coord} - {lo[15], lo};

    // The product is registered before the clamp.
    always_ff @(posedge clk)
    begin
        prod_reg <= diff[15:0] * scale;
    end

    // Clamp to the last bin in use.
    assign idx_raw = prod_reg[47:16];
    always_comb
    begin
        if (idx_raw >= 32'(nbins))
            index = IX_W'(nbins - BX_W'(1));
        else
            index = idx_raw[IX_W-1:0];
    end
endmodule
`default_nettype wire

/* rtl/wh2d_store.sv */
// Bin and region store: one synchronous memory for the grid, registers for regions.
`default_nettype none
module wh2d_store
    import wh2d_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic [CELL_AW-1:0] rd_addr,
    output logic [79:0]             rd_data,
    input  wire logic               wr_en,
    input  wire logic [CELL_AW-1:0] wr_addr,
    input  wire logic [79:0]        wr_data,
    input  wire logic [2:0]         edge_sel,
    output logic [79:0]             edge_data,
    input  wire logic               edge_wr,
    input  wire logic [79:0]        edge_wdata
);
    logic [79:0] mem [NCELLS];
    logic [79:0] edge_reg [8];

    // Cell memory: count in the upper 32 bits, weight in the lower 48.
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        rd_data <= mem[rd_addr];
    end

    // Eight region entries.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 8; i++)
                edge_reg[i] <= '0;
        end
        else if (edge_wr)
            edge_reg[edge_sel] <= edge_wdata;
    end

    assign edge_data = edge_reg[edge_sel];
endmodule
`default_nettype wire

/* rtl/weighted_2d_histogram_top.sv */
// Top level of the weighted 2D histogram: configuration, control and result register.
// After reset the block clears its 1024-entry cell memory, one entry a cycle, and
// stalls input until the clearing pass is done. After the transfer of a fill or read
// the item passes bin multiply, memory read, update and result (ST_BIN, ST_LOOKUP,
// ST_UPDATE, ST_OUT), and out_valid rises when it leaves ST_OUT. Input stays stalled
// while an item is in work or a result waits under out_stall, so a new item is taken
// only once the last one has left ST_OUT. An integrate walks the rectangle bin by bin
// in ST_SUM, then passes ST_SUM_LAST; an empty rectangle goes to ST_UPDATE like a fill.
`default_nettype none
module weighted_2d_histogram_top
    import wh2d_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_we,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [31:0]        cfg_data,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [1:0]         func,
    input  wire logic signed [15:0] x,
    input  wire logic signed [15:0] y,
    input  wire logic signed [15:0] x_high,
    input  wire logic signed [15:0] y_high,
    input  wire logic signed [15:0] weight,
    input  wire logic [10:0]        read_index,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [3:0]              region,
    output logic [31:0]             hit_count,
    output logic signed [47:0]      weight_sum,
    output logic [31:0]             entries
);
`include "assert_macros.svh"

    logic signed [15:0] min_x_reg, max_x_reg, min_y_reg, max_y_reg;
    logic [5:0]  bins_x_reg, bins_y_reg;
    logic [31:0] scale_x_reg, scale_y_reg;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_x_reg <= '0; max_x_reg <= 16'sd32767;
            min_y_reg <= '0; max_y_reg <= 16'sd32767;
            bins_x_reg <= 6'd32; bins_y_reg <= 6'd32;
            scale_x_reg <= 32'd65536; scale_y_reg <= 32'd65536;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_MIN_X:   min_x_reg   <= cfg_data[15:0];
                REG_MAX_X:   max_x_reg   <= cfg_data[15:0];
                REG_MIN_Y:   min_y_reg   <= cfg_data[15:0];
                REG_MAX_Y:   max_y_reg   <= cfg_data[15:0];
                REG_BINS_X:  bins_x_reg  <= cfg_data[5:0];
                REG_BINS_Y:  bins_y_reg  <= cfg_data[5:0];
                REG_SCALE_X: scale_x_reg <= cfg_data;
                REG_SCALE_Y: scale_y_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Effective bin counts.
    logic [BX_W-1:0] nbx;
    logic [BY_W-1:0] nby;
    always_comb
    begin
        if (bins_x_reg == '0) nbx = BX_W'(1);
        else if (32'(bins_x_reg) > MAX_BINS_X) nbx = BX_W'(MAX_BINS_X);
        else nbx = BX_W'(bins_x_reg);
        if (bins_y_reg == '0) nby = BY_W'(1);
        else if (32'(bins_y_reg) > MAX_BINS_Y) nby = BY_W'(MAX_BINS_Y);
        else nby = BY_W'(bins_y_reg);
    end

    // Captured item.
    logic [1:0]         func_reg;
    logic signed [15:0] x_reg, y_reg, xh_reg, yh_reg, w_reg;
    logic [10:0]        ridx_reg;
    logic               in_take;

    // Four binner instances: point or low corner, and high corner.
    logic [IX_W-1:0] bx_lo, bx_hi;
    logic [IY_W-1:0] by_lo, by_hi;
    wh2d_binner u_bin_xl (.clk, .coord(x_reg),  .lo(min_x_reg), .scale(scale_x_reg),
                          .nbins(nbx), .index(bx_lo));
    wh2d_binner u_bin_xh (.clk, .coord(xh_reg), .lo(min_x_reg), .scale(scale_x_reg),
                          .nbins(nbx), .index(bx_hi));
    wh2d_binner u_bin_yl (.clk, .coord(y_reg),  .lo(min_y_reg), .scale(scale_y_reg),
                          .nbins(BX_W'(nby)), .index(by_lo));
    wh2d_binner u_bin_yh (.clk, .coord(yh_reg), .lo(min_y_reg), .scale(scale_y_reg),
                          .nbins(BX_W'(nby)), .index(by_hi));

    // Range tests on the captured item.
    logic lox, hix, loy, hiy, inrange;
    logic xl_ok, xh_ok, yl_ok, yh_ok;
    logic [3:0] fill_rgn;
    assign lox = x_reg < min_x_reg;
    assign hix = x_reg >= max_x_reg;
    assign loy = y_reg < min_y_reg;
    assign hiy = y_reg >= max_y_reg;
    assign inrange = !(lox || hix || loy || hiy);
    assign xl_ok = (x_reg >= min_x_reg) && (x_reg <= max_x_reg);
    assign xh_ok = (xh_reg >= min_x_reg) && (xh_reg <= max_x_reg);
    assign yl_ok = (y_reg >= min_y_reg) && (y_reg <= max_y_reg);
    assign yh_ok = (yh_reg >= min_y_reg) && (yh_reg <= max_y_reg);

    always_comb
    begin
        if (inrange) fill_rgn = RGN_IN;
        else if (!(loy || hiy)) fill_rgn = lox ? RGN_XLO : RGN_XHI;
        else if (!(lox || hix)) fill_rgn = loy ? RGN_YLO : RGN_YHI;
        else if (lox && loy) fill_rgn = RGN_XLOYLO;
        else if (lox && hiy) fill_rgn = RGN_XLOYHI;
        else if (hix && loy) fill_rgn = RGN_XHIYLO;
        else fill_rgn = RGN_XHIYHI;
    end

    // Controller registers.
    state_t state_reg, state_next;
    logic [CLR_W-1:0]   clr_reg, clr_next;
    logic [IX_W-1:0]    lx_reg, hx_reg, ix_reg, ix_next;
    logic [IY_W-1:0]    hy_reg, iy_reg, iy_next;
    logic [CELL_AW-1:0] addr_reg, addr_next;
    logic [31:0]        entry_reg, entry_next;
    logic signed [47:0] sum_reg, sum_next;
    logic [3:0]         rgn_reg, rgn_next;
    logic               empty_reg;
    logic [3:0]         o_rgn_reg, o_rgn_next;
    logic [31:0]        o_cnt_reg, o_cnt_next;
    logic signed [47:0] o_w_reg, o_w_next;
    logic               o_valid_reg, o_valid_next;
    logic               rect_ok;
    logic [IX_W-1:0]    lx_c, hx_c;
    logic [IY_W-1:0]    ly_c, hy_c;
    logic [IX_W-1:0]    lx_next_hold, hx_next_hold;
    logic [IY_W-1:0]    hy_next_hold;
    logic               empty_next;

    // Store ports.
    logic [CELL_AW-1:0] rd_addr, wr_addr;
    logic [79:0]        rd_data, wr_data, edge_data, edge_wdata;
    logic               wr_en, edge_wr;
    logic [2:0]         edge_sel;

    wh2d_store u_store (.clk, .rst_n, .rd_addr, .rd_data, .wr_en, .wr_addr, .wr_data,
                        .edge_sel, .edge_data, .edge_wr, .edge_wdata);

    assign lx_c = xl_ok ? bx_lo : '0;
    assign hx_c = xh_ok ? bx_hi : IX_W'(nbx - BX_W'(1));
    assign ly_c = yl_ok ? by_lo : '0;
    assign hy_c = yh_ok ? by_hi : IY_W'(nby - BY_W'(1));
    assign rect_ok = (lx_c <= hx_c) && (ly_c <= hy_c);

    // Input waits while an item is in work or a result is held under stall.
    assign in_take = in_valid && !in_stall;
    assign in_stall = (state_reg != ST_IDLE) || (o_valid_reg && out_stall);

    // Item capture.
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            func_reg <= func; x_reg <= x; y_reg <= y;
            xh_reg <= x_high; yh_reg <= y_high; w_reg <= weight;
            ridx_reg <= read_index;
        end
        lx_reg <= lx_next_hold;
        hx_reg <= hx_next_hold;
        hy_reg <= hy_next_hold;
        rgn_reg <= rgn_next;
        empty_reg <= empty_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR; clr_reg <= '0; entry_reg <= '0; o_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next; clr_reg <= clr_next; entry_reg <= entry_next;
            o_valid_reg <= o_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ix_reg <= ix_next; iy_reg <= iy_next; addr_reg <= addr_next; sum_reg <= sum_next;
        o_rgn_reg <= o_rgn_next; o_cnt_reg <= o_cnt_next; o_w_reg <= o_w_next;
    end

    // Next state and datapath control.
    always_comb
    begin
        logic [31:0]        cnt_new;
        logic signed [47:0] w_new;
        logic [10:0]        eoff;
        state_next = state_reg; clr_next = clr_reg; entry_next = entry_reg;
        o_valid_next = o_valid_reg && out_stall;
        ix_next = ix_reg; iy_next = iy_reg; addr_next = addr_reg; sum_next = sum_reg;
        o_rgn_next = o_rgn_reg; o_cnt_next = o_cnt_reg; o_w_next = o_w_reg;
        lx_next_hold = lx_reg; hx_next_hold = hx_reg; hy_next_hold = hy_reg;
        rgn_next = rgn_reg; empty_next = empty_reg;
        rd_addr = addr_reg; wr_en = 1'b0; wr_addr = addr_reg; wr_data = '0;
        eoff = ridx_reg - EDGE_BASE;
        edge_sel = (state_reg == ST_UPDATE && func_reg == FUNC_READ) ? eoff[2:0]
                 : 3'(rgn_reg - 4'd1);
        edge_wr = 1'b0; edge_wdata = '0;
        cnt_new = '0; w_new = '0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                wr_en = 1'b1; wr_addr = clr_reg[CELL_AW-1:0];
                clr_next = clr_reg + CLR_W'(1);
                if (clr_reg == CLR_W'(NCELLS - 1)) state_next = ST_IDLE;
            end
            ST_IDLE:
                if (in_take) state_next = ST_BIN;
            // The binners register the products of the captured item.
            ST_BIN:
                state_next = ST_LOOKUP;
            ST_LOOKUP:
            begin
                // Binner outputs are valid now; form the cell address.
                addr_next = CELL_AW'(32'(by_lo) * 32'(nbx) + 32'(bx_lo));
                rd_addr = addr_next;
                rgn_next = fill_rgn;
                lx_next_hold = lx_c; hx_next_hold = hx_c; hy_next_hold = hy_c;
                empty_next = !rect_ok;
                ix_next = lx_c; iy_next = ly_c; sum_next = '0;
                if (func_reg == FUNC_READ)
                begin
                    addr_next = ridx_reg[CELL_AW-1:0];
                    rd_addr = addr_next;
                end
                if (func_reg == FUNC_INTEG)
                begin
                    addr_next = CELL_AW'(32'(ly_c) * 32'(nbx) + 32'(lx_c));
                    rd_addr = addr_next;
                    state_next = rect_ok ? ST_SUM : ST_UPDATE;
                end
                else
                    state_next = ST_UPDATE;
            end
            ST_SUM:
            begin
                // One bin a cycle: accumulate the current read, issue the next.
                sum_next = sat_add48(sum_reg, rd_data[47:0]);
                if (ix_reg == hx_reg && iy_reg == hy_reg)
                    state_next = ST_SUM_LAST;
                else
                begin
                    if (ix_reg == hx_reg)
                    begin
                        ix_next = lx_reg; iy_next = iy_reg + IY_W'(1);
                    end
                    else
                        ix_next = ix_reg + IX_W'(1);
                    addr_next = CELL_AW'(32'(iy_next) * 32'(nbx) + 32'(ix_next));
                    rd_addr = addr_next;
                end
            end
            ST_SUM_LAST:
                state_next = ST_UPDATE;
            ST_UPDATE:
            begin
                o_rgn_next = 4'd0; o_cnt_next = '0; o_w_next = '0;
                case (func_reg)
                    FUNC_FILL:
                    begin
                        entry_next = sat_inc32(entry_reg);
                        if (rgn_reg == RGN_IN)
                        begin
                            cnt_new = sat_inc32(rd_data[79:48]);
                            w_new = sat_add48(rd_data[47:0], 48'(w_reg));
                            wr_en = 1'b1; wr_data = {cnt_new, w_new};
                        end
                        else
                        begin
                            cnt_new = sat_inc32(edge_data[79:48]);
                            w_new = sat_add48(edge_data[47:0], 48'(w_reg));
                            edge_wr = 1'b1; edge_wdata = {cnt_new, w_new};
                        end
                        o_rgn_next = rgn_reg; o_cnt_next = cnt_new; o_w_next = w_new;
                    end
                    FUNC_READ:
                    begin
                        if (ridx_reg < 11'(NCELLS))
                        begin
                            o_cnt_next = rd_data[79:48]; o_w_next = rd_data[47:0];
                        end
                        else if (ridx_reg >= EDGE_BASE && ridx_reg < EDGE_END)
                        begin
                            o_rgn_next = 4'(eoff[2:0]) + 4'd1;
                            o_cnt_next = edge_data[79:48]; o_w_next = edge_data[47:0];
                        end
                    end
                    FUNC_INTEG: o_w_next = empty_reg ? '0 : sum_reg;
                    default: ;
                endcase
                state_next = ST_OUT;
            end
            ST_OUT:
                if (!o_valid_reg || !out_stall)
                begin
                    o_valid_next = 1'b1; state_next = ST_IDLE;
                end
            default: state_next = ST_IDLE;
        endcase
    end

    // In ST_UPDATE for an integrate the final sum is in sum_reg.
    assign out_valid  = o_valid_reg;
    assign region     = o_rgn_reg;
    assign hit_count  = o_cnt_reg;
    assign weight_sum = o_w_reg;
    assign entries    = entry_reg;

    `ASSERT_IMPL(a_no_take_busy, clk, rst_n,
        (state_reg != ST_IDLE) |-> !in_take, "item taken while busy")
    `ASSERT_IMPL(a_out_hold, clk, rst_n,
        (o_valid_reg && out_stall) |=> o_valid_reg, "result dropped under stall")
    `ASSERT_NEVER(a_no_mem_in_clear, clk, rst_n,
        (state_reg == ST_CLEAR) && o_valid_reg, "result during clearing pass")
    `ASSERT_NEVER(a_no_update_held, clk, rst_n,
        (state_reg == ST_UPDATE) && o_valid_reg, "result overwritten while held")
endmodule
`default_nettype wire
